>>> src/hhg_pkg.sv
// package: types, constants and lookup tables for the gating-variable update block
`timescale 1ns / 1ps

package hhg_pkg;

    // table geometry
    localparam int SIG_DEPTH = 256;
    localparam int EXP_DEPTH = 256;
    localparam int SIG_IDX_W = $clog2(SIG_DEPTH + 1);
    localparam int EXP_IDX_W = $clog2(EXP_DEPTH + 1);

    // datapath widths
    localparam int TAB_W  = 33;
    localparam int ITAU_W = 30;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // fixed constants
    localparam logic [63:0] ONE_Q32    = 64'h1_0000_0000;
    localparam logic [63:0] LN2_Q32    = 64'd2977044472;
    localparam logic [63:0] TAU_FLOOR  = 64'd99466609;
    localparam logic signed [17:0] REVERSAL_Q8 = 18'sd20480;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] membrane_v;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        gate_m;
        logic signed [31:0] chan_current;
    } out_item_t;

    // config register indexes
    typedef enum logic {
        CFG_CONDUCTANCE = 1'b0,
        CFG_TIME_STEP   = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        CMD_INTEGRATE = 1'b0,
        CMD_SET_STEADY = 1'b1
    } item_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MINF,
        ST_TARGET,
        ST_ITAU,
        ST_RATIO,
        ST_DECAY,
        ST_RELAX,
        ST_APPLY,
        ST_GAIN,
        ST_CURRENT,
        ST_DONE
    } ctl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MINF,
        OP_TARGET,
        OP_ITAU,
        OP_RATIO,
        OP_DECAY,
        OP_RELAX,
        OP_APPLY,
        OP_GAIN,
        OP_CURRENT,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        logic   load_in;
        dp_op_t op;
    } ctl_cmd_t;

    typedef struct packed {
        logic direct;
        logic out_busy;
    } dp_status_t;

    typedef logic [TAB_W-1:0]  sig_tab_t  [0:SIG_DEPTH];
    typedef logic [ITAU_W-1:0] itau_tab_t [0:SIG_DEPTH];
    typedef logic [TAB_W-1:0]  dec_tab_t  [0:EXP_DEPTH];

    // restoring division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-y) in q32 by range reduction and a truncated series
    function automatic logic [63:0] exp_neg(input logic [63:0] y);
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] term;
        logic [63:0] sum;
        n    = y / LN2_Q32;
        f    = y - n * LN2_Q32;
        term = ONE_Q32;
        sum  = ONE_Q32;
        for (int i = 1; i <= 16; i++) begin
            term = udiv64((term * f) >> 32, 64'(i));
            if (i[0]) begin
                sum = sum - term;
            end
            else begin
                sum = sum + term;
            end
        end
        return (n >= 64) ? 64'd0 : (sum >> n);
    endfunction

    function automatic logic [63:0] logistic(input logic neg, input logic [63:0] mag);
        logic [63:0] s;
        s = udiv64(64'hFFFF_FFFF_FFFF_FFFF, ONE_Q32 + exp_neg(mag));
        return neg ? (ONE_Q32 - s) : s;
    endfunction

    function automatic sig_tab_t build_minf();
        sig_tab_t    t;
        longint      n;
        longint      a;
        logic [63:0] ma;
        logic [63:0] x;
        for (int k = 0; k <= SIG_DEPTH; k++) begin
            n  = longint'(k) * 65536 - 32768 * longint'(SIG_DEPTH);
            a  = 10 * n + 17664 * longint'(SIG_DEPTH);
            ma = (a < 0) ? 64'(-a) : 64'(a);
            x  = udiv64(ma << 32, 64'(SIG_DEPTH) * 64'd256 * 64'd149);
            t[k] = TAB_W'(logistic(a < 0, x));
        end
        return t;
    endfunction

    function automatic itau_tab_t build_itau();
        itau_tab_t   t;
        longint      n;
        longint      b;
        logic [63:0] mb;
        logic [63:0] w;
        logic [63:0] s;
        logic [63:0] tau;
        for (int k = 0; k <= SIG_DEPTH; k++) begin
            n   = longint'(k) * 65536 - 32768 * longint'(SIG_DEPTH);
            b   = 10 * n + 313856 * longint'(SIG_DEPTH);
            mb  = (b < 0) ? 64'(-b) : 64'(b);
            w   = udiv64(mb << 32, 64'(SIG_DEPTH) * 64'd256 * 64'd138);
            s   = logistic(b >= 0, w);
            tau = ((64'd18458 * s) >> 16) / 10 + TAU_FLOOR;
            t[k] = ITAU_W'(udiv64(64'd1 << 56, tau));
        end
        return t;
    endfunction

    function automatic dec_tab_t build_decay();
        dec_tab_t t;
        for (int k = 0; k <= EXP_DEPTH; k++) begin
            t[k] = TAB_W'(exp_neg(udiv64(64'(k) << 32, 64'(EXP_DEPTH))));
        end
        return t;
    endfunction

    localparam sig_tab_t  MINF_TAB  = build_minf();
    localparam itau_tab_t ITAU_TAB  = build_itau();
    localparam dec_tab_t  DECAY_TAB = build_decay();

endpackage

>>> src/hhg_ctrl.sv
// controller: sequences one item through the shared-multiplier datapath
`timescale 1ns / 1ps

module hhg_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  hhg_pkg::dp_status_t status,
    output hhg_pkg::ctl_cmd_t   cmd
);
    import hhg_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next  = state_reg;
        cmd.load_in = 1'b0;
        cmd.op      = OP_NONE;
        in_stall    = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MINF;
                end
            end
            ST_MINF:
            begin
                cmd.op     = OP_MINF;
                state_next = ST_TARGET;
            end
            ST_TARGET:
            begin
                cmd.op     = OP_TARGET;
                state_next = status.direct ? ST_GAIN : ST_ITAU;
            end
            ST_ITAU:
            begin
                cmd.op     = OP_ITAU;
                state_next = ST_RATIO;
            end
            ST_RATIO:
            begin
                cmd.op     = OP_RATIO;
                state_next = ST_DECAY;
            end
            ST_DECAY:
            begin
                cmd.op     = OP_DECAY;
                state_next = ST_RELAX;
            end
            ST_RELAX:
            begin
                cmd.op     = OP_RELAX;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.op     = OP_APPLY;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.op     = OP_GAIN;
                state_next = ST_CURRENT;
            end
            ST_CURRENT:
            begin
                cmd.op     = OP_CURRENT;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/hhg_datapath.sv
// datapath: table interpolation, gate relaxation and current, on one shared multiplier
`timescale 1ns / 1ps

module hhg_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  hhg_pkg::ctl_cmd_t   cmd,
    output hhg_pkg::dp_status_t status,
    input  hhg_pkg::in_item_t   in_item,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               out_valid,
    input  logic               out_stall,
    output hhg_pkg::out_item_t  out_item
);
    import hhg_pkg::*;

    // control and state registers
    logic [15:0] conductance_reg;
    logic [15:0] time_step_reg;
    logic [15:0] gate_value_reg;
    logic        gate_ready_reg;
    logic        out_valid_reg;

    // payload registers
    logic signed [15:0]   v_reg;
    logic                 cmd_reg;
    logic [SIG_IDX_W-1:0] vi_reg;
    logic [15:0]          vf_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_next;
    logic                 up_reg;
    logic                 up_next;
    logic [15:0]          t_reg;
    logic [EXP_IDX_W-1:0] di_reg;
    logic [15:0]          df_reg;
    logic                 mge_reg;
    out_item_t            out_item_reg;

    // combinational
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [15:0]          offset;
    logic [31:0]          pos;
    logic [SIG_IDX_W-1:0] vi_hi;
    logic [TAB_W-1:0]     ss_a;
    logic [TAB_W-1:0]     ss_b;
    logic [TAB_W-1:0]     ss_diff;
    logic [ITAU_W-1:0]    it_a;
    logic [ITAU_W-1:0]    it_b;
    logic [ITAU_W-1:0]    it_diff;
    logic [ITAU_W-1:0]    itau;
    logic [EXP_IDX_W-1:0] di_hi;
    logic [TAB_W-1:0]     dc_a;
    logic [TAB_W-1:0]     dc_b;
    logic [TAB_W-1:0]     dc_diff;
    logic [TAB_W-1:0]     minf;
    logic [TAB_W:0]       minf_rnd;
    logic [15:0]          t_sat;
    logic [TAB_W-1:0]     decay;
    logic [15:0]          mt_diff;
    logic [63:0]          ratio;
    logic [PROD_W:0]      relax_rnd;
    logic [17:0]          relax_step;
    logic [16:0]          m_up;
    logic [15:0]          m_new;
    logic signed [17:0]   drive;
    logic [16:0]          drive_mag;
    logic [48:0]          cur_rnd;
    logic [24:0]          cur_mag;
    logic [31:0]          cur_mag_sat;

    // voltage to table position
    assign offset = {~in_item.membrane_v[15], in_item.membrane_v[14:0]};
    assign pos    = 32'(offset) * 32'(SIG_DEPTH);

    // table reads around the stored position
    assign vi_hi   = vi_reg + SIG_IDX_W'(1);
    assign ss_a    = MINF_TAB[vi_reg];
    assign ss_b    = MINF_TAB[vi_hi];
    assign ss_diff = (ss_b >= ss_a) ? (ss_b - ss_a) : (ss_a - ss_b);
    assign it_a    = ITAU_TAB[vi_reg];
    assign it_b    = ITAU_TAB[vi_hi];
    assign it_diff = (it_b >= it_a) ? (it_b - it_a) : (it_a - it_b);
    assign di_hi   = (di_reg == EXP_IDX_W'(EXP_DEPTH)) ? di_reg : di_reg + EXP_IDX_W'(1);
    assign dc_a    = DECAY_TAB[di_reg];
    assign dc_b    = DECAY_TAB[di_hi];
    assign dc_diff = (dc_b >= dc_a) ? (dc_b - dc_a) : (dc_a - dc_b);

    // interpolated values from the last product
    assign minf  = up_reg ? (ss_a + prod_reg[48:16]) : (ss_a - prod_reg[48:16]);
    assign itau  = up_reg ? (it_a + ITAU_W'(prod_reg[48:16]))
                          : (it_a - ITAU_W'(prod_reg[48:16]));
    assign decay = up_reg ? (dc_a + prod_reg[48:16]) : (dc_a - prod_reg[48:16]);

    // steady-state target, rounded and saturated
    assign minf_rnd = {1'b0, minf} + (TAB_W+1)'(32768);
    assign t_sat    = (minf_rnd[TAB_W:16] > 18'd65535) ? 16'hFFFF : minf_rnd[31:16];

    // decay table position from dt / tau
    assign ratio = 64'(prod_reg[45:0]) * 64'(EXP_DEPTH);

    // relaxation toward the target
    assign mt_diff    = mge_reg ? (gate_value_reg - t_reg) : (t_reg - gate_value_reg);
    assign relax_rnd  = {1'b0, prod_reg} + (PROD_W+1)'(64'h8000_0000);
    assign relax_step = relax_rnd[49:32];
    assign m_up       = 17'(t_reg) + 17'(relax_step);
    always_comb
    begin
        if (mge_reg)
        begin
            m_new = m_up[16] ? 16'hFFFF : m_up[15:0];
        end
        else
        begin
            m_new = t_reg - relax_step[15:0];
        end
    end

    // driving force and current magnitude
    assign drive       = 18'(v_reg) + REVERSAL_Q8;
    assign drive_mag   = drive[17] ? 17'(-drive) : drive[16:0];
    assign cur_rnd     = 49'(prod_reg[47:0]) + 49'(24'h80_0000);
    assign cur_mag     = cur_rnd[48:24];
    assign cur_mag_sat = (drive[17] && 32'(cur_mag) > 32'h8000_0000) ? 32'h8000_0000 :
                         (!drive[17] && 32'(cur_mag) > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF :
                         32'(cur_mag);

    // shared multiplier operand select
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        up_next = up_reg;
        unique case (cmd.op)
            OP_MINF:
            begin
                mul_a   = ss_diff;
                mul_b   = {1'b0, vf_reg};
                up_next = ss_b >= ss_a;
            end
            OP_TARGET:
            begin
                mul_a   = MUL_A_W'(it_diff);
                mul_b   = {1'b0, vf_reg};
                up_next = it_b >= it_a;
            end
            OP_ITAU:
            begin
                mul_a = MUL_A_W'(itau);
                mul_b = {1'b0, time_step_reg};
            end
            OP_DECAY:
            begin
                mul_a   = dc_diff;
                mul_b   = {1'b0, df_reg};
                up_next = dc_b >= dc_a;
            end
            OP_RELAX:
            begin
                mul_a = decay;
                mul_b = {1'b0, mt_diff};
            end
            OP_GAIN:
            begin
                mul_a = MUL_A_W'(conductance_reg);
                mul_b = {1'b0, gate_value_reg};
            end
            OP_CURRENT:
            begin
                mul_a = {1'b0, prod_reg[31:0]};
                mul_b = drive_mag;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conductance_reg <= 16'd256;
            time_step_reg   <= 16'd256;
            gate_value_reg  <= '0;
            gate_ready_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_CONDUCTANCE)
                begin
                    conductance_reg <= cfg_data;
                end
                else
                begin
                    time_step_reg <= cfg_data;
                end
            end
            if (cmd.op == OP_TARGET && status.direct)
            begin
                gate_value_reg <= t_sat;
                gate_ready_reg <= 1'b1;
            end
            if (cmd.op == OP_APPLY)
            begin
                gate_value_reg <= m_new;
            end
            if (cmd.op == OP_FINISH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            v_reg   <= in_item.membrane_v;
            cmd_reg <= in_item.cmd;
            vi_reg  <= SIG_IDX_W'(pos >> 16);
            vf_reg  <= pos[15:0];
        end
        if (cmd.op != OP_NONE && cmd.op != OP_FINISH && cmd.op != OP_APPLY &&
            cmd.op != OP_RATIO)
        begin
            prod_reg <= prod_next;
            up_reg   <= up_next;
        end
        if (cmd.op == OP_TARGET)
        begin
            t_reg <= t_sat;
        end
        if (cmd.op == OP_RATIO)
        begin
            if (ratio[63:48] >= 16'(EXP_DEPTH))
            begin
                di_reg <= EXP_IDX_W'(EXP_DEPTH);
            end
            else
            begin
                di_reg <= EXP_IDX_W'(ratio[63:48]);
            end
            df_reg <= ratio[47:32];
        end
        // direction of the gate against the target, ready before the relax product
        if (cmd.op == OP_DECAY)
        begin
            mge_reg <= gate_value_reg >= t_reg;
        end
        if (cmd.op == OP_FINISH)
        begin
            out_item_reg.gate_m       <= gate_value_reg;
            out_item_reg.chan_current <= drive[17] ? -$signed(cur_mag_sat)
                                                   : $signed(cur_mag_sat);
        end
    end

    assign status.direct   = (cmd_reg == CMD_SET_STEADY) || !gate_ready_reg;
    assign status.out_busy = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign out_item        = out_item_reg;

endmodule

>>> src/hh_gate_exp_euler_step.sv
// top level: gating-variable exponential-euler step with current output
`timescale 1ns / 1ps

// One item carries a command and a membrane voltage (signed Q8.8 mV) and gives
// one result: the updated gate (Q0.16) and the channel current g*m*(V+80) in
// pA Q23.8. Work runs through a single shared 33x17 multiplier, at most one
// product per cycle, and no new item is taken until the last one finishes;
// a set-steady item (or the first after reset) skips the relaxation steps.
// A result still stalled on the output register holds the next result in the
// done state of its item; otherwise the next input item is taken while a
// finished result still waits. Sigmoid, 1/tau and decay exponential tables
// are constants built at elaboration. The user must write conductance and time
// step on the config port while the block is idle, unchecked by the block.
module hh_gate_exp_euler_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  hhg_pkg::in_item_t  in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output hhg_pkg::out_item_t out_item,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data
);
    import hhg_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    // sequencer
    hhg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and state
    hhg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

`ifndef NO_ASSERTIONS
    // an accepted item keeps the input side closed the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted again right after an accept");

    // a new result only appears while an item is in work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no item in work");

    // a closed gate carries no current
    a_zero_gate_zero_current: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.gate_m == 16'd0) |-> (out_item.chan_current == 32'sd0))
        else $error("current nonzero with gate closed");
`endif

endmodule
